// ----- rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// Spaced seed matcher package
// Shared constants, configuration types and the base decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int unsigned WINDOW_BITS   = 24;
  localparam int unsigned POSITION_BITS = 20;
  localparam int unsigned SEED_BITS     = 24;
  localparam int unsigned CODE_BITS     = 2;
  localparam int unsigned SYMBOL_BITS   = 8;
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned FIFO_DEPTH    = 4;

  // ASCII characters of the four bases.
  localparam logic [SYMBOL_BITS-1:0] SYM_A_UP = 8'h41;
  localparam logic [SYMBOL_BITS-1:0] SYM_T_UP = 8'h54;
  localparam logic [SYMBOL_BITS-1:0] SYM_C_UP = 8'h43;
  localparam logic [SYMBOL_BITS-1:0] SYM_G_UP = 8'h47;
  localparam logic [SYMBOL_BITS-1:0] SYM_A_LO = 8'h61;
  localparam logic [SYMBOL_BITS-1:0] SYM_T_LO = 8'h74;
  localparam logic [SYMBOL_BITS-1:0] SYM_C_LO = 8'h63;
  localparam logic [SYMBOL_BITS-1:0] SYM_G_LO = 8'h67;

  typedef enum logic [2:0] {
    REG_CODE_A     = 3'd0,
    REG_CODE_T     = 3'd1,
    REG_CODE_C     = 3'd2,
    REG_CODE_G     = 3'd3,
    REG_SEED_MASK  = 3'd4,
    REG_SEED_VALUE = 3'd5
  } ssm_reg_e;

  typedef struct packed {
    logic [CODE_BITS-1:0] code_a;
    logic [CODE_BITS-1:0] code_t;
    logic [CODE_BITS-1:0] code_c;
    logic [CODE_BITS-1:0] code_g;
    logic [SEED_BITS-1:0] seed_mask;
    logic [SEED_BITS-1:0] seed_value;
  } ssm_cfg_t;

  typedef struct packed {
    logic                 is_base;
    logic [CODE_BITS-1:0] code;
  } ssm_base_t;

  function automatic ssm_base_t decode_symbol(input logic [SYMBOL_BITS-1:0] sym,
                                              input ssm_cfg_t cfg);
    ssm_base_t res;
    res.is_base = 1'b1;
    res.code    = '0;
    case (sym) inside
      SYM_A_UP, SYM_A_LO: res.code = cfg.code_a;
      SYM_T_UP, SYM_T_LO: res.code = cfg.code_t;
      SYM_C_UP, SYM_C_LO: res.code = cfg.code_c;
      SYM_G_UP, SYM_G_LO: res.code = cfg.code_g;
      default:            res.is_base = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/spaced_seed_matcher.sv -----
// ----------------------------------------------------------------------------
// Spaced seed matcher
// Datapath: each accepted character is held in the input register, its hits are
// written into the output queue when it has room and are offered from there.
// Throughput: one character per cycle while the output queue has room; the output
// sends at most one word per cycle, so bases that each give two hits can hold back input.
// Reset clears window, bit count and queue; registers return to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spaced_seed_matcher #(
  parameter int unsigned WindowBits   = ssm_pkg::WINDOW_BITS,
  parameter int unsigned PositionBits = ssm_pkg::POSITION_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ssm_pkg::SYMBOL_BITS-1:0]       s_axis_tdata,  // [7:0] symbol
  input  logic                                  s_axis_tuser,  // [0] first
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((PositionBits+7)/8)*8-1:0]     m_axis_tdata,  // position, zero filled
  output logic                                  m_axis_tlast,  // last_of_run
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ssm_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [ssm_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [ssm_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);
  import ssm_pkg::*;

  localparam int unsigned OutBits = ((PositionBits + 7) / 8) * 8;

  ssm_cfg_t              cfg;
  logic                  room;
  logic [1:0]            push_cnt;
  logic [PositionBits:0] push_a, push_b, out_word;

  ssm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssm_core #(
    .WindowBits   (WindowBits),
    .PositionBits (PositionBits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .symbol_i   (s_axis_tdata),
    .first_i    (s_axis_tuser),
    .room_i     (room),
    .push_cnt_o (push_cnt),
    .push_a_o   (push_a),
    .push_b_o   (push_b)
  );

  ssm_out_fifo #(
    .PositionBits (PositionBits)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_a_i    (push_a),
    .push_b_i    (push_b),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_word)
  );

  assign m_axis_tdata = OutBits'(out_word[PositionBits-1:0]);
  assign m_axis_tlast = out_word[PositionBits];

endmodule

// ----- rtl/ssm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Spaced seed matcher configuration registers
// APB register file holding the base codes and the seed mask and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ssm_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [ssm_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [ssm_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output ssm_pkg::ssm_cfg_t                   cfg_o
);
  import ssm_pkg::*;

  ssm_cfg_t cfg_q, cfg_d;
  ssm_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = ssm_reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CODE_A:     cfg_d.code_a     = pwdata[CODE_BITS-1:0];
        REG_CODE_T:     cfg_d.code_t     = pwdata[CODE_BITS-1:0];
        REG_CODE_C:     cfg_d.code_c     = pwdata[CODE_BITS-1:0];
        REG_CODE_G:     cfg_d.code_g     = pwdata[CODE_BITS-1:0];
        REG_SEED_MASK:  cfg_d.seed_mask  = pwdata[SEED_BITS-1:0];
        REG_SEED_VALUE: cfg_d.seed_value = pwdata[SEED_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CODE_A:     prdata = APB_DATA_BITS'(cfg_q.code_a);
      REG_CODE_T:     prdata = APB_DATA_BITS'(cfg_q.code_t);
      REG_CODE_C:     prdata = APB_DATA_BITS'(cfg_q.code_c);
      REG_CODE_G:     prdata = APB_DATA_BITS'(cfg_q.code_g);
      REG_SEED_MASK:  prdata = APB_DATA_BITS'(cfg_q.seed_mask);
      REG_SEED_VALUE: prdata = APB_DATA_BITS'(cfg_q.seed_value);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_a     <= 2'd0;
      cfg_q.code_t     <= 2'd1;
      cfg_q.code_c     <= 2'd2;
      cfg_q.code_g     <= 2'd3;
      cfg_q.seed_mask  <= '0;
      cfg_q.seed_value <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ssm_core.sv -----
// ----------------------------------------------------------------------------
// Spaced seed matcher core
// Input register, window and bit count, and the two per-base seed compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_core #(
  parameter int unsigned WindowBits   = ssm_pkg::WINDOW_BITS,
  parameter int unsigned PositionBits = ssm_pkg::POSITION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssm_pkg::ssm_cfg_t                   cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ssm_pkg::SYMBOL_BITS-1:0]     symbol_i,
  input  logic                                first_i,
  input  logic                                room_i,
  output logic [1:0]                          push_cnt_o,
  output logic [PositionBits:0]               push_a_o,
  output logic [PositionBits:0]               push_b_o
);
  import ssm_pkg::*;

  localparam int unsigned CmpBits  = (WindowBits > SEED_BITS) ? WindowBits : SEED_BITS;
  localparam longint unsigned LimitVal =
      ((64'd1 << PositionBits) - 64'd1) + 64'(WindowBits);
  localparam int unsigned SeenBits = $clog2(LimitVal + 64'd1);
  localparam logic [SeenBits-1:0] SeenLimit = SeenBits'(LimitVal);
  localparam logic [SeenBits-1:0] WinCount  = SeenBits'(WindowBits);

  logic                   valid_q, valid_d;
  logic [SYMBOL_BITS-1:0] symbol_q;
  logic                   first_q;
  logic [WindowBits-1:0]  window_q, window_d;
  logic [SeenBits-1:0]    seen_q, seen_d;

  ssm_base_t              base;
  logic                   fire;
  logic [WindowBits-1:0]  win0, win1, win2;
  logic [SeenBits-1:0]    seen0, seen1, seen2;
  logic                   en0, en1, hit0, hit1;
  logic [PositionBits-1:0] pos0, pos1;

  function automatic logic seed_match(input logic [WindowBits-1:0] win,
                                      input ssm_cfg_t cfg);
    logic [CmpBits-1:0] w_x, m_x, v_x;
    w_x = CmpBits'(win);
    m_x = CmpBits'(cfg.seed_mask);
    v_x = CmpBits'(cfg.seed_value);
    return (w_x & m_x) == v_x;
  endfunction

  assign fire       = valid_q & room_i;
  assign in_ready_o = ~valid_q | room_i;
  assign valid_d    = (in_valid_i & in_ready_o) | (valid_q & ~room_i);

  // Both code bits go through the window in the same cycle, low bit first.
  always_comb begin
    base  = decode_symbol(symbol_q, cfg_i);
    win0  = first_q ? '0 : window_q;
    seen0 = first_q ? '0 : seen_q;

    en0  = base.is_base & (seen0 < SeenLimit);
    win1 = en0 ? {base.code[0], win0[WindowBits-1:1]} : win0;
    seen1 = en0 ? seen0 + SeenBits'(1) : seen0;
    hit0 = en0 & (seen1 >= WinCount) & seed_match(win1, cfg_i);
    pos0 = PositionBits'(seen1 - WinCount);

    en1  = base.is_base & (seen1 < SeenLimit);
    win2 = en1 ? {base.code[1], win1[WindowBits-1:1]} : win1;
    seen2 = en1 ? seen1 + SeenBits'(1) : seen1;
    hit1 = en1 & (seen2 >= WinCount) & seed_match(win2, cfg_i);
    pos1 = PositionBits'(seen2 - WinCount);

    window_d = fire ? win2 : window_q;
    seen_d   = fire ? seen2 : seen_q;

    push_cnt_o = fire ? (2'(hit0) + 2'(hit1)) : 2'd0;
    push_a_o   = hit0 ? {~hit1, pos0} : {1'b1, pos1};
    push_b_o   = {1'b1, pos1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      window_q <= '0;
      seen_q   <= '0;
    end else begin
      valid_q  <= valid_d;
      window_q <= window_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      symbol_q <= symbol_i;
      first_q  <= first_i;
    end
  end

`ifndef SYNTH
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenLimit)
    else $error("bit count passed its saturation limit");

  a_double_hit_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && hit0 && hit1) |-> (pos1 == pos0 + PositionBits'(1)))
    else $error("two hits of one base are not at adjacent positions");

  a_hit_needs_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (hit0 || hit1)) |-> base.is_base)
    else $error("hit reported for a dropped character");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_o != 2'd0) |-> room_i)
    else $error("results pushed without room in the output queue");
`endif

endmodule

// ----- rtl/ssm_out_fifo.sv -----
// ----------------------------------------------------------------------------
// Spaced seed matcher output queue
// Small register queue that takes up to two hits a cycle and sends one when the output is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_out_fifo #(
  parameter int unsigned PositionBits = ssm_pkg::POSITION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_cnt_i,
  input  logic [PositionBits:0] push_a_i,
  input  logic [PositionBits:0] push_b_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PositionBits:0] out_data_o
);
  import ssm_pkg::*;

  localparam int unsigned PtrBits = $clog2(FIFO_DEPTH);
  localparam int unsigned CntBits = $clog2(FIFO_DEPTH + 1);
  localparam logic [CntBits-1:0] RoomMax = CntBits'(FIFO_DEPTH - 2);

  logic [PositionBits:0] entry_q [FIFO_DEPTH];
  logic [PtrBits-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]    count_q, count_d;
  logic                  pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  // Room is kept for a two-hit base regardless of this cycle's pop.
  assign room_o      = (count_q <= RoomMax);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrBits'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrBits'(pop);
    count_d  = count_q + CntBits'(push_cnt_i) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_q + PtrBits'(1)] <= push_b_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_pop_only_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt_i == 2'd0) |=> (count_q == $past(count_q) - CntBits'(1)))
    else $error("queue count did not drop after a lone pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CntBits'(FIFO_DEPTH)) |-> (PtrBits'(wr_ptr_q - rd_ptr_q) == PtrBits'(count_q)))
    else $error("queue pointers disagree with the count");
`endif

endmodule
